/* hdl/aspc_pkg.sv */
// Shared types and constants of the stride prefetching page cache.
// No dependencies; every file of the block but aspc_ram refers to this package.
package aspc_pkg;

    // Default sizes of the block.
    localparam int unsigned PAGE_BITS_DEF = 10;
    localparam int unsigned MAX_DEPTH_DEF = 8;

    // Width of a prefetch depth; holds depths up to 31.
    localparam int unsigned DEPTH_W = 5;

    localparam int unsigned ELAPSED_W = 16;

    // Input opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_WRITE    = 2'd0;
    localparam logic [1:0] KIND_DEMAND   = 2'd1;
    localparam logic [1:0] KIND_PREFETCH = 2'd2;

    // Stride confidence.
    localparam int unsigned CONF_W      = 4;
    localparam logic [3:0]  CONF_MAX    = 4'd8;
    localparam logic [3:0]  CONF_THRESH = 4'd3;
    localparam logic [3:0]  CONF_DROP   = 4'd2;

    // Average time between reads, in ms with 8 fraction bits.
    localparam int unsigned TAU_W     = 20;
    localparam logic [19:0] TAU_RESET = 20'd2560;

    // tau' = floor((85 * tau + 15 * delta + 50) / 100); the numerator fits 27 bits.
    localparam int unsigned TAU_NUM_W = 27;
    localparam int unsigned EMA_KEEP  = 85;
    localparam int unsigned EMA_NEW   = 15;
    localparam int unsigned EMA_ROUND = 50;
    localparam int unsigned EMA_DIV   = 100;

    // Division by 100 as a multiply by a truncated reciprocal; the estimate is
    // at most one below the true quotient and gets one corrective step.
    localparam int unsigned RECIP_SHIFT = 27;
    localparam int unsigned RECIP_W     = 21;
    localparam int unsigned RECIP_MUL   = (1 << RECIP_SHIFT) / EMA_DIV;

    // depth = largest k up to the maximum depth with k * (100 * tau + 256) <= 307200.
    localparam int unsigned DEPTH_BIAS  = 256;
    localparam int unsigned DEPTH_LIMIT = 307200;

    typedef struct packed {
        logic                 start;
        logic [ELAPSED_W-1:0] elapsed_time;
    } tau_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DEPTH_W-1:0] depth;
    } tau_rsp_t;

endpackage

/* hdl/aspc_if.sv */
// Valid/ready channel interfaces for request and result words.
// Depends on aspc_pkg for the default page width.
interface aspc_in_if #(
    parameter int unsigned PAGE_BITS = aspc_pkg::PAGE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [PAGE_BITS-1:0] page_number;
    logic [15:0]          elapsed_time;

    modport source (output valid, output opcode, output page_number,
                     output elapsed_time, input ready);
    modport sink   (input valid, input opcode, input page_number,
                     input elapsed_time, output ready);
endinterface

interface aspc_out_if #(
    parameter int unsigned PAGE_BITS = aspc_pkg::PAGE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [PAGE_BITS-1:0] result_page;
    logic                 hit;
    logic                 found;
    logic [31:0]          hit_total;
    logic [31:0]          miss_total;
    logic                 last;

    modport source (output valid, output kind, output result_page, output hit,
                     output found, output hit_total, output miss_total,
                     output last, input ready);
    modport sink   (input valid, input kind, input result_page, input hit,
                     input found, input hit_total, input miss_total,
                     input last, output ready);
endinterface

/* hdl/aspc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module aspc_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* hdl/aspc_tau.sv */
// Read-interval averaging unit: updates tau over three pipeline stages and then
// derives the prefetch depth from it. Depends on aspc_pkg.
module aspc_tau #(
    parameter int unsigned MAX_DEPTH = aspc_pkg::MAX_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  aspc_pkg::tau_req_t req,
    output aspc_pkg::tau_rsp_t rsp
);
    localparam int unsigned NW = aspc_pkg::TAU_NUM_W;
    localparam int unsigned RW = aspc_pkg::RECIP_W;
    localparam int unsigned PW = NW + RW;
    localparam int unsigned TW = aspc_pkg::TAU_W;
    localparam int unsigned DW = aspc_pkg::DEPTH_W;
    localparam int unsigned SH = aspc_pkg::RECIP_SHIFT;

    logic [TW-1:0] tau_reg, tau_next;
    logic          seen_reg;
    logic          v1_reg, v2_reg, v3_reg, done_reg;
    logic          upd1_reg, upd2_reg;
    logic [NW-1:0] num1_reg, num_next;
    logic [NW-1:0] num2_reg;
    logic [PW-1:0] prod_reg, prod_next;
    logic [DW-1:0] depth_reg, depth_next;

    logic [PW-SH-1:0] quot_est;
    logic [NW-1:0]    rem;
    logic [NW-1:0]    quot;
    logic [NW-1:0]    base;
    logic [MAX_DEPTH:1] pass;

    // Stage 1: numerator of the weighted average, rounding term included.
    assign num_next = NW'(tau_reg) * NW'(aspc_pkg::EMA_KEEP)
                    + NW'({req.elapsed_time, 4'b0000}) * NW'(aspc_pkg::EMA_NEW)
                    + NW'(aspc_pkg::EMA_ROUND);

    // Stage 2: quotient estimate by reciprocal.
    assign prod_next = PW'(num1_reg) * PW'(aspc_pkg::RECIP_MUL);

    // Stage 3: one correction brings the estimate to the exact floor.
    assign quot_est = prod_reg[PW-1:SH];
    assign rem      = num2_reg - NW'(quot_est) * NW'(aspc_pkg::EMA_DIV);
    assign quot     = NW'(quot_est) + NW'(rem >= NW'(aspc_pkg::EMA_DIV));
    assign tau_next = (v2_reg && upd2_reg) ? quot[TW-1:0] : tau_reg;

    // Depth: threshold compares against the elaboration-time limits 307200 / k.
    assign base    = NW'(tau_reg) * NW'(aspc_pkg::EMA_DIV) + NW'(aspc_pkg::DEPTH_BIAS);
    assign pass[1] = 1'b1;

    for (genvar k = 2; k <= MAX_DEPTH; k++)
    begin : g_lim
        localparam int unsigned LIM = aspc_pkg::DEPTH_LIMIT / k;
        assign pass[k] = (base <= NW'(LIM));
    end

    always_comb
    begin
        depth_next = DW'(1);
        for (int k = 1; k <= MAX_DEPTH; k++)
        begin
            if (pass[k])
            begin
                depth_next = DW'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_reg  <= aspc_pkg::TAU_RESET;
            seen_reg <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
            upd1_reg <= 1'b0;
            upd2_reg <= 1'b0;
        end
        else
        begin
            tau_reg  <= tau_next;
            v1_reg   <= req.start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
            upd2_reg <= upd1_reg;
            if (req.start)
            begin
                // The first read leaves tau as it is.
                upd1_reg <= seen_reg;
                seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num1_reg <= num_next;
        end
        if (v1_reg)
        begin
            prod_reg <= prod_next;
            num2_reg <= num1_reg;
        end
        if (v3_reg)
        begin
            depth_reg <= depth_next;
        end
    end

    assign rsp.busy  = v1_reg | v2_reg | v3_reg;
    assign rsp.done  = done_reg;
    assign rsp.depth = depth_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !(v1_reg || v2_reg || v3_reg))
        else $error("tau update started while another is in flight");

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (depth_reg >= DW'(1) && depth_reg <= DW'(MAX_DEPTH)))
        else $error("prefetch depth out of range");

    a_first_keeps_tau: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !upd2_reg) |=> $stable(tau_reg))
        else $error("first read changed tau");
endmodule

/* hdl/adaptive_stride_prefetch_cache_unit.sv */
// Stride prefetching page cache: top level with the request sequencer.
// Depends on aspc_pkg, aspc_if (aspc_in_if, aspc_out_if), aspc_ram and aspc_tau.
//
// After reset the block clears both presence memories, one page per cycle, and
// accepts no request word until that is done. After a read, the three-stage tau
// averaging unit must drain before the next request word is taken. A read that
// prefetches goes through one demand lookup, a wait for the depth, then one
// probe of the presence memories per prefetch distance through their single
// read port, a drain step and the final result. Each result word is held in a
// one-deep look-behind stage so that the last flag can be set, and a stalled
// result port stalls probing.
module adaptive_stride_prefetch_cache_unit #(
    parameter int unsigned PAGE_BITS = aspc_pkg::PAGE_BITS_DEF,
    parameter int unsigned MAX_DEPTH = aspc_pkg::MAX_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    aspc_in_if.sink    req,
    aspc_out_if.source rsp
);
    localparam int unsigned NPAGES = 1 << PAGE_BITS;
    localparam int unsigned SW     = PAGE_BITS + 1;
    localparam int unsigned TGW    = PAGE_BITS + $clog2(MAX_DEPTH + 1) + 2;
    localparam int unsigned DW     = aspc_pkg::DEPTH_W;
    localparam int unsigned CW     = aspc_pkg::CONF_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_WAIT  = 6'b001000,
        S_PROBE = 6'b010000,
        S_END   = 6'b100000
    } state_t;

    state_t st_reg, st_next;

    logic [PAGE_BITS-1:0]  clr_idx_reg, clr_idx_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [PAGE_BITS-1:0]  prev_reg, prev_next;
    logic signed [SW-1:0]  stride_reg, stride_next;
    logic [CW-1:0]         conf_reg, conf_next;
    logic [31:0]           hit_cnt_reg, hit_cnt_next;
    logic [31:0]           miss_cnt_reg, miss_cnt_next;
    logic signed [TGW-1:0] tgt_reg, tgt_next;
    logic [DW-1:0]         depth_reg, depth_next;
    logic [DW-1:0]         d_reg, d_next;
    logic                  prb_vld_reg, prb_vld_next;
    logic [PAGE_BITS-1:0]  prb_page_reg, prb_page_next;

    logic                  pend_vld_reg, pend_vld_next;
    logic [1:0]            pend_kind_reg, pend_kind_next;
    logic [PAGE_BITS-1:0]  pend_page_reg, pend_page_next;
    logic                  pend_hit_reg, pend_hit_next;
    logic                  pend_found_reg, pend_found_next;

    logic                  out_vld_reg, out_vld_next;
    logic                  out_load;
    logic                  out_last;
    logic [1:0]            out_kind_reg;
    logic [PAGE_BITS-1:0]  out_page_reg;
    logic                  out_hit_reg;
    logic                  out_found_reg;
    logic [31:0]           out_hit_total_reg;
    logic [31:0]           out_miss_total_reg;
    logic                  out_last_reg;

    logic                  st_we, st_wdata, st_rdata;
    logic [PAGE_BITS-1:0]  st_waddr;
    logic                  ca_we, ca_wdata, ca_rdata;
    logic [PAGE_BITS-1:0]  ca_waddr;
    logic                  mem_re;
    logic [PAGE_BITS-1:0]  mem_raddr;

    aspc_pkg::tau_req_t    tau_req;
    aspc_pkg::tau_rsp_t    tau_rsp;

    logic                  accept;
    logic                  out_free;
    logic signed [SW-1:0]  cur_stride;
    logic                  produce;
    logic                  tgt_in_range;

    aspc_ram #(.WIDTH(1), .DEPTH(NPAGES)) u_stored (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (st_rdata)
    );

    aspc_ram #(.WIDTH(1), .DEPTH(NPAGES)) u_cached (
        .clk   (clk),
        .we    (ca_we),
        .waddr (ca_waddr),
        .wdata (ca_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (ca_rdata)
    );

    aspc_tau #(.MAX_DEPTH(MAX_DEPTH)) u_tau (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tau_req),
        .rsp   (tau_rsp)
    );

    assign req.ready    = (st_reg == S_IDLE) && !tau_rsp.busy;
    assign accept       = req.valid && req.ready;
    assign out_free     = !out_vld_reg || rsp.ready;
    assign cur_stride   = $signed({1'b0, page_reg}) - $signed({1'b0, prev_reg});
    assign produce      = prb_vld_reg && st_rdata && !ca_rdata;
    assign tgt_in_range = (tgt_reg[TGW-1:PAGE_BITS] == '0);

    always_comb
    begin
        st_next         = st_reg;
        clr_idx_next    = clr_idx_reg;
        page_next       = page_reg;
        prev_next       = prev_reg;
        stride_next     = stride_reg;
        conf_next       = conf_reg;
        hit_cnt_next    = hit_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        tgt_next        = tgt_reg;
        depth_next      = depth_reg;
        d_next          = d_reg;
        prb_vld_next    = prb_vld_reg;
        prb_page_next   = prb_page_reg;
        pend_vld_next   = pend_vld_reg;
        pend_kind_next  = pend_kind_reg;
        pend_page_next  = pend_page_reg;
        pend_hit_next   = pend_hit_reg;
        pend_found_next = pend_found_reg;
        out_load        = 1'b0;
        out_last        = 1'b0;

        st_we     = 1'b0;
        st_waddr  = page_reg;
        st_wdata  = 1'b1;
        ca_we     = 1'b0;
        ca_waddr  = page_reg;
        ca_wdata  = 1'b1;
        mem_re    = 1'b0;
        mem_raddr = req.page_number;

        tau_req.start        = 1'b0;
        tau_req.elapsed_time = req.elapsed_time;

        case (st_reg)
            S_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_idx_reg;
                st_wdata = 1'b0;
                ca_we    = 1'b1;
                ca_waddr = clr_idx_reg;
                ca_wdata = 1'b0;
                if (clr_idx_reg == '1)
                begin
                    st_next = S_IDLE;
                end
                clr_idx_next = clr_idx_reg + 1'b1;
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    page_next = req.page_number;
                    if (req.opcode == aspc_pkg::OP_WRITE)
                    begin
                        st_we           = 1'b1;
                        st_waddr        = req.page_number;
                        pend_vld_next   = 1'b1;
                        pend_kind_next  = aspc_pkg::KIND_WRITE;
                        pend_page_next  = req.page_number;
                        pend_hit_next   = 1'b0;
                        pend_found_next = 1'b1;
                        st_next         = S_END;
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        tau_req.start = 1'b1;
                        st_next       = S_LOOK;
                    end
                end
            end

            S_LOOK:
            begin
                if (ca_rdata)
                begin
                    if (hit_cnt_reg != '1)
                    begin
                        hit_cnt_next = hit_cnt_reg + 32'd1;
                    end
                end
                else
                begin
                    if (miss_cnt_reg != '1)
                    begin
                        miss_cnt_next = miss_cnt_reg + 32'd1;
                    end
                    ca_we = st_rdata;
                end
                pend_vld_next   = 1'b1;
                pend_kind_next  = aspc_pkg::KIND_DEMAND;
                pend_page_next  = page_reg;
                pend_hit_next   = ca_rdata;
                pend_found_next = st_rdata;

                if (cur_stride == stride_reg)
                begin
                    if (conf_reg < aspc_pkg::CONF_MAX)
                    begin
                        conf_next = conf_reg + 1'b1;
                    end
                end
                else
                begin
                    conf_next   = (conf_reg >= aspc_pkg::CONF_DROP)
                                ? conf_reg - aspc_pkg::CONF_DROP : '0;
                    stride_next = cur_stride;
                end
                prev_next = page_reg;
                tgt_next  = TGW'($signed({1'b0, page_reg})) + TGW'(stride_next);

                if (conf_next >= aspc_pkg::CONF_THRESH && stride_next != '0)
                begin
                    st_next = S_WAIT;
                end
                else
                begin
                    st_next = S_END;
                end
            end

            S_WAIT:
            begin
                if (tau_rsp.done)
                begin
                    depth_next   = tau_rsp.depth;
                    d_next       = '0;
                    prb_vld_next = 1'b0;
                    st_next      = S_PROBE;
                end
            end

            S_PROBE:
            begin
                // A found page waits here while the result port is full; the
                // memory read data hold because no new read is issued.
                if (!(produce && !out_free))
                begin
                    if (produce)
                    begin
                        ca_we           = 1'b1;
                        ca_waddr        = prb_page_reg;
                        out_load        = 1'b1;
                        pend_kind_next  = aspc_pkg::KIND_PREFETCH;
                        pend_page_next  = prb_page_reg;
                        pend_hit_next   = 1'b0;
                        pend_found_next = 1'b1;
                    end
                    if (d_reg < depth_reg)
                    begin
                        // Targets outside the page space are skipped without a read.
                        mem_re        = tgt_in_range;
                        mem_raddr     = tgt_reg[PAGE_BITS-1:0];
                        prb_vld_next  = tgt_in_range;
                        prb_page_next = tgt_reg[PAGE_BITS-1:0];
                        d_next        = d_reg + 1'b1;
                        tgt_next      = tgt_reg + TGW'(stride_reg);
                    end
                    else
                    begin
                        prb_vld_next = 1'b0;
                        st_next      = S_END;
                    end
                end
            end

            S_END:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last      = 1'b1;
                    pend_vld_next = 1'b0;
                    st_next       = S_IDLE;
                end
            end

            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        out_vld_next = out_load || (out_vld_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_CLEAR;
            clr_idx_reg   <= '0;
            prev_reg      <= '0;
            stride_reg    <= SW'(1);
            conf_reg      <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            prb_vld_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
            d_reg         <= '0;
            depth_reg     <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            clr_idx_reg   <= clr_idx_next;
            prev_reg      <= prev_next;
            stride_reg    <= stride_next;
            conf_reg      <= conf_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            prb_vld_reg   <= prb_vld_next;
            pend_vld_reg  <= pend_vld_next;
            out_vld_reg   <= out_vld_next;
            d_reg         <= d_next;
            depth_reg     <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        tgt_reg        <= tgt_next;
        prb_page_reg   <= prb_page_next;
        pend_kind_reg  <= pend_kind_next;
        pend_page_reg  <= pend_page_next;
        pend_hit_reg   <= pend_hit_next;
        pend_found_reg <= pend_found_next;
        if (out_load)
        begin
            out_kind_reg       <= pend_kind_reg;
            out_page_reg       <= pend_page_reg;
            out_hit_reg        <= pend_hit_reg;
            out_found_reg      <= pend_found_reg;
            out_hit_total_reg  <= hit_cnt_reg;
            out_miss_total_reg <= miss_cnt_reg;
            out_last_reg       <= out_last;
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.kind        = out_kind_reg;
    assign rsp.result_page = out_page_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.hit_total   = out_hit_total_reg;
    assign rsp.miss_total  = out_miss_total_reg;
    assign rsp.last        = out_last_reg;

    a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_IDLE) |-> !pend_vld_reg)
        else $error("held result word left over between requests");

    a_probe_count: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_PROBE) |-> (d_reg <= depth_reg))
        else $error("more probes issued than the prefetch depth");

    a_probe_not_demand: assert property (@(posedge clk) disable iff (!rst_n)
        (ca_we && st_reg == S_PROBE) |-> (ca_waddr != page_reg))
        else $error("prefetch fill hit the demand page");
endmodule

/* tb/adaptive_stride_prefetch_cache_unit_tb.sv */
// Self-checking testbench for the stride prefetching page cache.
// Holds a scoreboard class that predicts every result word, plus driving tasks.
// Depends on aspc_pkg, aspc_if and the adaptive_stride_prefetch_cache_unit RTL.
`timescale 1ns / 1ps

module adaptive_stride_prefetch_cache_unit_tb;

    localparam int unsigned PAGE_BITS = aspc_pkg::PAGE_BITS_DEF;
    localparam int unsigned MAX_DEPTH = aspc_pkg::MAX_DEPTH_DEF;
    localparam int unsigned ELAPSED_W = aspc_pkg::ELAPSED_W;
    localparam int unsigned TAU_W = aspc_pkg::TAU_W;
    localparam int unsigned CONF_W = aspc_pkg::CONF_W;
    localparam int          NPAGES = 1 << PAGE_BITS;
    localparam int          RANDOM_ITEMS = 350;
    localparam int          QUIET_LIMIT = 4000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          DEPTH_SCALE = 100;
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0]           kind;
        logic [PAGE_BITS-1:0] page;
        logic                 hit;
        logic                 found;
        logic [31:0]          hit_total;
        logic [31:0]          miss_total;
        logic                 last;
    } cache_word_t;

    class prefetch_scoreboard;
        bit                         in_store [NPAGES];
        bit                         in_cache [NPAGES];
        logic [31:0]                read_hits;
        logic [31:0]                read_misses;
        logic [TAU_W-1:0]           avg_gap;
        bit                         any_read;
        logic [PAGE_BITS-1:0]       last_read_page;
        logic signed [PAGE_BITS:0]  run_stride;
        logic [CONF_W-1:0]          run_conf;
        cache_word_t                pending_words [$];
        int                         mismatches;
        int                         words_checked;
        int                         reads_seen;
        int                         prefetches_seen;

        function new();
            foreach (in_store[i])
            begin
                in_store[i] = 1'b0;
                in_cache[i] = 1'b0;
            end
            read_hits = '0;
            read_misses = '0;
            avg_gap = aspc_pkg::TAU_RESET;
            any_read = 1'b0;
            last_read_page = '0;
            run_stride = 1;
            run_conf = '0;
            mismatches = 0;
            words_checked = 0;
            reads_seen = 0;
            prefetches_seen = 0;
        endfunction

        function void push_word(logic [1:0] kind, logic [PAGE_BITS-1:0] page,
                                logic hit, logic found);
            cache_word_t w;
            w.kind = kind;
            w.page = page;
            w.hit = hit;
            w.found = found;
            w.hit_total = read_hits;
            w.miss_total = read_misses;
            w.last = 1'b0;
            pending_words.push_back(w);
        endfunction

        function void note_request(logic op, logic [PAGE_BITS-1:0] page,
                                   logic [ELAPSED_W-1:0] elapsed);
            logic                      was_hit;
            logic                      was_found;
            logic signed [PAGE_BITS:0] cur_stride;
            longint                    numer;
            longint                    span;
            int                        depth;
            int                        target;
            if (op == aspc_pkg::OP_WRITE)
            begin
                in_store[page] = 1'b1;
                push_word(aspc_pkg::KIND_WRITE, page, 1'b0, 1'b1);
                pending_words[$].last = 1'b1;
                return;
            end
            reads_seen++;
            was_hit = in_cache[page];
            was_found = in_store[page];
            if (was_hit)
            begin
                if (read_hits != 32'hFFFF_FFFF)
                    read_hits++;
            end
            else
            begin
                if (read_misses != 32'hFFFF_FFFF)
                    read_misses++;
                if (was_found)
                    in_cache[page] = 1'b1;
            end
            push_word(aspc_pkg::KIND_DEMAND, page, was_hit, was_found);

            // The gap is in 1/16 ms; times 16 gives ms with 8 fraction bits.
            if (any_read)
            begin
                numer = longint'(aspc_pkg::EMA_KEEP) * longint'(avg_gap)
                      + longint'(aspc_pkg::EMA_NEW) * longint'(elapsed) * 16
                      + longint'(aspc_pkg::EMA_ROUND);
                avg_gap = TAU_W'(numer / longint'(aspc_pkg::EMA_DIV));
            end
            any_read = 1'b1;

            cur_stride = $signed({1'b0, page}) - $signed({1'b0, last_read_page});
            if (cur_stride == run_stride)
            begin
                if (run_conf < aspc_pkg::CONF_MAX)
                    run_conf++;
            end
            else
            begin
                run_conf = (run_conf >= aspc_pkg::CONF_DROP)
                         ? run_conf - aspc_pkg::CONF_DROP : '0;
                run_stride = cur_stride;
            end
            last_read_page = page;

            depth = 0;
            if (run_conf >= aspc_pkg::CONF_THRESH && run_stride != 0)
            begin
                span = longint'(DEPTH_SCALE) * longint'(avg_gap)
                     + longint'(aspc_pkg::DEPTH_BIAS);
                depth = 1;
                for (int k = 2; k <= MAX_DEPTH; k++)
                    if (longint'(k) * span <= longint'(aspc_pkg::DEPTH_LIMIT))
                        depth = k;
            end
            for (int d = 1; d <= depth; d++)
            begin
                target = int'(page) + d * int'(run_stride);
                if (target < 0 || target >= NPAGES)
                    continue;
                if (in_store[target] && !in_cache[target])
                begin
                    in_cache[target] = 1'b1;
                    prefetches_seen++;
                    push_word(aspc_pkg::KIND_PREFETCH, PAGE_BITS'(target), 1'b0, 1'b1);
                end
            end
            pending_words[$].last = 1'b1;
        endfunction

        function string show(cache_word_t w);
            return $sformatf("kind=%0d page=%0d hit=%0b found=%0b hits=%0d misses=%0d last=%0b",
                             w.kind, w.page, w.hit, w.found, w.hit_total, w.miss_total,
                             w.last);
        endfunction

        function void check_word(cache_word_t got);
            cache_word_t want;
            string       bad;
            words_checked++;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result word with nothing pending: %s", $time, show(got));
                return;
            end
            want = pending_words.pop_front();
            bad = "";
            if (got.kind != want.kind)             bad = {bad, " kind"};
            if (got.page != want.page)             bad = {bad, " result_page"};
            if (got.hit != want.hit)               bad = {bad, " hit"};
            if (got.found != want.found)           bad = {bad, " found"};
            if (got.hit_total != want.hit_total)   bad = {bad, " hit_total"};
            if (got.miss_total != want.miss_total) bad = {bad, " miss_total"};
            if (got.last != want.last)             bad = {bad, " last"};
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: mismatch in%s", $time, bad);
                    $display("    expected %s", show(want));
                    $display("    actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;
    int   sent_count;

    aspc_in_if  #(.PAGE_BITS(PAGE_BITS)) req ();
    aspc_out_if #(.PAGE_BITS(PAGE_BITS)) rsp ();

    adaptive_stride_prefetch_cache_unit #(
        .PAGE_BITS(PAGE_BITS),
        .MAX_DEPTH(MAX_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    prefetch_scoreboard sb = new();

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic op, input logic [PAGE_BITS-1:0] page,
                                input logic [ELAPSED_W-1:0] elapsed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= op;
        req.page_number <= page;
        req.elapsed_time <= elapsed;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(op, page, elapsed);
        sent_count++;
        if (sent_count < 110)
        begin
            send_idle_pct = 0;
            stall_pct = 0;
        end
        else if (sent_count < 200)
        begin
            send_idle_pct = 70;
            stall_pct = 0;
        end
        else if (sent_count < 290)
        begin
            send_idle_pct = 0;
            stall_pct = 70;
        end
        else
        begin
            send_idle_pct = 38;
            stall_pct = 38;
        end
        @(negedge clk);
    endtask

    // Mostly short gaps so that the average falls and deep prefetch opens up.
    function automatic logic [ELAPSED_W-1:0] read_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return ELAPSED_W'($urandom_range(65535));
        else if (pick < 15)
            return ELAPSED_W'($urandom_range(1023));
        return ELAPSED_W'($urandom_range(40));
    endfunction

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            sb.check_word('{rsp.kind, rsp.result_page, rsp.hit, rsp.found,
                            rsp.hit_total, rsp.miss_total, rsp.last});
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int pick;
        int run_step;
        int runs;
        int base;
        int p;
        int goal;
        int left;
        send_idle_pct = 0;
        stall_pct = 0;
        sent_count = 0;
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.opcode <= aspc_pkg::OP_WRITE;
        req.page_number <= '0;
        req.elapsed_time <= '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Page extremes, a first read, a repeat hit, a miss with nothing stored.
        send_request(aspc_pkg::OP_WRITE, '0, '0);
        send_request(aspc_pkg::OP_WRITE, PAGE_BITS'(NPAGES - 1), 16'hFFFF);
        send_request(aspc_pkg::OP_READ, PAGE_BITS'(NPAGES - 1), 16'hFFFF);
        send_request(aspc_pkg::OP_READ, PAGE_BITS'(NPAGES - 1), '0);
        send_request(aspc_pkg::OP_READ, PAGE_BITS'(NPAGES / 2), '0);
        send_request(aspc_pkg::OP_READ, '0, '0);
        // A stride of two toward the top: prefetch kicks in, then runs off the end.
        for (p = NPAGES - 11; p <= NPAGES - 3; p += 2)
            send_request(aspc_pkg::OP_WRITE, PAGE_BITS'(p),
                         ELAPSED_W'($urandom_range(65535)));
        for (p = NPAGES - 19; p <= NPAGES - 1; p += 2)
            send_request(aspc_pkg::OP_READ, PAGE_BITS'(p), '0);

        goal = sent_count + RANDOM_ITEMS;
        while (sent_count < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                run_step = $urandom_range(1, 12);
                if ($urandom_range(1))
                    run_step = -run_step;
                if ($urandom_range(9) == 0)
                    run_step = 0;
                runs = $urandom_range(4, 10);
                base = $urandom_range(NPAGES - 1);
                if ($urandom_range(3) == 0)
                    base = $urandom_range(1) ? $urandom_range(15)
                                             : NPAGES - 1 - $urandom_range(15);
                // Store most pages of the run and some beyond it for prefetch.
                for (int i = 0; i < runs + int'(MAX_DEPTH); i++)
                begin
                    p = base + i * run_step;
                    if (p < 0 || p >= NPAGES)
                        break;
                    if ($urandom_range(99) < 75)
                        send_request(aspc_pkg::OP_WRITE, PAGE_BITS'(p),
                                     ELAPSED_W'($urandom_range(65535)));
                end
                for (int i = 0; i < runs; i++)
                begin
                    p = base + i * run_step;
                    if (p < 0 || p >= NPAGES)
                        break;
                    send_request(aspc_pkg::OP_READ, PAGE_BITS'(p), read_gap());
                end
            end
            else if (pick < 80)
                send_request(aspc_pkg::OP_WRITE, PAGE_BITS'($urandom_range(NPAGES - 1)),
                             ELAPSED_W'($urandom_range(65535)));
            else
                send_request(aspc_pkg::OP_READ, PAGE_BITS'($urandom_range(NPAGES - 1)),
                             $urandom_range(1) ? ELAPSED_W'($urandom_range(65535))
                                               : read_gap());
        end
        req.valid <= 1'b0;

        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        left = sb.pending_words.size();
        if (left != 0)
        begin
            sb.mismatches++;
            $display("%0d expected result words never arrived", left);
        end
        $display("Sent %0d request words (%0d reads); checked %0d result words, %0d prefetches.",
                 sent_count, sb.reads_seen, sb.words_checked, sb.prefetches_seen);
        $display("Idle phases: none, sender 70%%, receiver 70%%, both 38%%; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
